FILE: design/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg
// shared widths, defaults and the cell control bundle of the insertion sorter
// ----------------------------------------------------------------------------
package sis_pkg;

    localparam int SIS_KEY_W    = 16;
    localparam int SIS_TAG_W    = 16;
    localparam int SIS_CAPACITY = 64;

    // per-cycle command from the sequencer to every cell
    typedef struct packed {
        logic ins;   // a new entry is being placed into the row
        logic shl;   // the row moves one place toward cell 0 (drain)
    } t_cell_ctrl;

endpackage

FILE: design/sis_cell.sv
// ----------------------------------------------------------------------------
// sis_cell
// one slot of the sorted row: holds a key and a tag, compares against the
// incoming key and takes the new entry, the left neighbor or the right one
// ----------------------------------------------------------------------------
module sis_cell
    import sis_pkg::*;
(
    input  logic                 i_clk,
    input  t_cell_ctrl           i_ctrl,
    input  logic                 i_occupied,
    input  logic [SIS_KEY_W-1:0] i_new_key,
    input  logic [SIS_TAG_W-1:0] i_new_tag,
    input  logic                 i_prev_moves,
    input  logic [SIS_KEY_W-1:0] i_left_key,
    input  logic [SIS_TAG_W-1:0] i_left_tag,
    input  logic [SIS_KEY_W-1:0] i_right_key,
    input  logic [SIS_TAG_W-1:0] i_right_tag,
    output logic                 o_moves,
    output logic [SIS_KEY_W-1:0] o_key,
    output logic [SIS_TAG_W-1:0] o_tag
);

    logic [SIS_KEY_W-1:0] r_key;
    logic [SIS_TAG_W-1:0] r_tag;

    // equal keys stay ahead of the new one, so the sort is stable
    assign o_moves = !i_occupied || (r_key > i_new_key);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shl) begin
            r_key <= i_right_key;
            r_tag <= i_right_tag;
        end else if (i_ctrl.ins && o_moves) begin
            if (i_prev_moves) begin
                r_key <= i_left_key;
                r_tag <= i_left_tag;
            end else begin
                r_key <= i_new_key;
                r_tag <= i_new_tag;
            end
        end
    end

    assign o_key = r_key;
    assign o_tag = r_tag;

endmodule

FILE: design/stable_insertion_sorter_top.sv
// ----------------------------------------------------------------------------
// stable_insertion_sorter_top
// stable ascending insertion sorter with group framing
// ----------------------------------------------------------------------------
// Items enter at one per cycle while no group drains and are placed into a
// row of CAPACITY cells in the same cycle: every cell compares its key with
// the incoming one and the row opens a gap by shifting one place, whatever
// the fill. Equal keys keep their arrival order. An item with tlast set is
// inserted (or dropped if the row is full), then the input stalls while the
// row drains through cell 0, one entry per cycle at the output's pace, before
// the next request is taken. Items arriving while the row is full are dropped
// and tuser is set on every result of that group.
// ----------------------------------------------------------------------------
module stable_insertion_sorter_top
    import sis_pkg::*;
#(
    parameter int CAPACITY = SIS_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] rank_key, [31:16] item_tag
    input  logic        i_s_axis_tlast,   // group_end
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] out_rank, [31:16] out_tag
    output logic        o_m_axis_tlast,   // final_entry
    output logic [0:0]  o_m_axis_tuser    // dropped_flag
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_drain, n_drain;
    logic             r_ovf, n_ovf;

    logic             in_acc, out_acc, full;
    t_cell_ctrl       ctrl;

    logic [SIS_KEY_W-1:0] new_key;
    logic [SIS_TAG_W-1:0] new_tag;

    logic [SIS_KEY_W-1:0] cell_key   [CAPACITY];
    logic [SIS_TAG_W-1:0] cell_tag   [CAPACITY];
    logic                 cell_moves [CAPACITY];

    assign new_key = i_s_axis_tdata[SIS_KEY_W-1:0];
    assign new_tag = i_s_axis_tdata[SIS_KEY_W +: SIS_TAG_W];

    assign o_s_axis_tready = !r_drain;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc         = o_m_axis_tvalid && i_m_axis_tready;
    assign full            = (r_fill == CNT_W'(CAPACITY));

    assign ctrl.ins = in_acc && !full;
    assign ctrl.shl = out_acc;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                 prev_moves;
            logic [SIS_KEY_W-1:0] left_key, right_key;
            logic [SIS_TAG_W-1:0] left_tag, right_tag;

            if (gi == 0) begin : g_head
                assign prev_moves = 1'b0;
                assign left_key   = new_key;
                assign left_tag   = new_tag;
            end else begin : g_body
                assign prev_moves = cell_moves[gi-1];
                assign left_key   = cell_key[gi-1];
                assign left_tag   = cell_tag[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign right_key = '0;
                assign right_tag = '0;
            end else begin : g_inner
                assign right_key = cell_key[gi+1];
                assign right_tag = cell_tag[gi+1];
            end

            sis_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (ctrl),
                .i_occupied   (CNT_W'(gi) < r_fill),
                .i_new_key    (new_key),
                .i_new_tag    (new_tag),
                .i_prev_moves (prev_moves),
                .i_left_key   (left_key),
                .i_left_tag   (left_tag),
                .i_right_key  (right_key),
                .i_right_tag  (right_tag),
                .o_moves      (cell_moves[gi]),
                .o_key        (cell_key[gi]),
                .o_tag        (cell_tag[gi])
            );
        end
    endgenerate

    always_comb begin
        n_fill  = r_fill;
        n_drain = r_drain;
        n_ovf   = r_ovf;
        if (in_acc) begin
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_fill = r_fill + CNT_W'(1);
            end
            if (i_s_axis_tlast) begin
                n_drain = 1'b1;
            end
        end
        if (out_acc) begin
            n_fill = r_fill - CNT_W'(1);
            // last entry of the group leaves
            if (r_fill == CNT_W'(1)) begin
                n_drain = 1'b0;
                n_ovf   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_drain <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_drain <= n_drain;
            r_ovf   <= n_ovf;
        end
    end

    assign o_m_axis_tvalid = r_drain;
    assign o_m_axis_tdata  = {cell_tag[0], cell_key[0]};
    assign o_m_axis_tlast  = (r_fill == CNT_W'(1));
    assign o_m_axis_tuser  = r_ovf;

endmodule

FILE: design/sis_checker.sv
// ----------------------------------------------------------------------------
// sis_checker
// port-level checks of the insertion sorter, bound to the top level
// ----------------------------------------------------------------------------
module sis_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic        o_m_axis_tlast
);

    // input is closed while a group drains
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while output drains");

    // a closing request starts the drain on the next cycle
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> o_m_axis_tvalid)
        else $error("group end did not start emission");

    // nothing follows the final entry of a group
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=> !o_m_axis_tvalid)
        else $error("output continued after final entry");

    // a stalled output stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("output request withdrawn");

endmodule

bind stable_insertion_sorter_top sis_checker u_sis_checker (.*);
